// File: design/cfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capture frame deframer package
// Shared types, codes and sizing constants for the deframer blocks.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int MAX_DIM_DEF = 4096;
    localparam int FIFO_DEPTH  = 4;

    // Header layout, in words.
    localparam logic [3:0] HW_MAGIC     = 4'd0;
    localparam logic [3:0] HW_WIDTH     = 4'd2;
    localparam logic [3:0] HW_HEIGHT    = 4'd3;
    localparam logic [3:0] HW_STRIDE    = 4'd4;
    localparam logic [3:0] HW_FORMAT    = 4'd5;
    localparam logic [3:0] HW_PAYLOAD   = 4'd6;
    localparam logic [3:0] HW_PANEL_W   = 4'd7;
    localparam logic [3:0] HW_PANEL_H   = 4'd8;
    localparam logic [3:0] HDR_SHORT_LAST = 4'd6;
    localparam logic [3:0] HDR_LONG_LAST  = 4'd8;
    localparam logic [31:0] LONG_HDR_VERSION = 32'd2;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_CONNECT = 2'd1,
        OP_STOP    = 2'd2
    } op_e;

    typedef enum logic [1:0] {
        K_PIXEL = 2'd0,
        K_FRAME = 2'd1,
        K_HELLO = 2'd2,
        K_DROP  = 2'd3
    } kind_e;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_HELLO_MAG = 3'd1,
        ERR_VERSION   = 3'd2,
        ERR_FRAME_MAG = 3'd3,
        ERR_HEADER    = 3'd4
    } err_e;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_HELLO      = 3'd1,
        PH_HELLO_BAD  = 3'd2,
        PH_HEADER     = 3'd3,
        PH_HEADER_BAD = 3'd4,
        PH_DATA       = 3'd5,
        PH_PAD        = 3'd6
    } phase_e;

    typedef enum logic [1:0] {
        REG_HELLO_MAGIC = 2'd0,
        REG_FRAME_MAGIC = 2'd1,
        REG_MIN_VERSION = 2'd2,
        REG_MAX_VERSION = 2'd3
    } reg_e;

    typedef struct packed {
        logic [31:0] hello_magic;
        logic [31:0] frame_magic;
        logic [31:0] min_version;
        logic [31:0] max_version;
    } cfg_t;

    typedef struct packed {
        kind_e       kind;
        logic [7:0]  pixel_byte;
        logic [25:0] pixel_offset;
        logic [12:0] width;
        logic [12:0] height;
        logic [31:0] panel_width;
        logic [31:0] panel_height;
        logic [31:0] frame_number;
        err_e        error_code;
        logic        last;
    } result_t;

endpackage

// File: design/cfd_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer stream parser
// Assembles words, checks hello and headers, repacks rows, issues results.
// ----------------------------------------------------------------------------
module cfd_parse #(
    parameter int MAX_DIM = cfd_pkg::MAX_DIM_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cfd_pkg::cfg_t   cfg,
    input  logic            take,
    input  logic [1:0]      op,
    input  logic [7:0]      data_byte,
    output logic [1:0]      res_count,
    output cfd_pkg::result_t res0,
    output cfd_pkg::result_t res1
);
    import cfd_pkg::*;

    localparam longint unsigned MAX_BYTES = 64'(MAX_DIM) * 64'(MAX_DIM) * 64'd4;
    localparam int DW = $clog2(MAX_DIM + 2);
    localparam int SW = $clog2(MAX_BYTES) + 1;
    localparam int OW = $clog2(MAX_BYTES);
    localparam logic [31:0] DIM_MAX = 32'(MAX_DIM);
    localparam logic [DW-1:0] DIM_SAT = DW'(MAX_DIM + 1);
    localparam logic [31:0] STRIDE_SAT = 32'((64'd1 << SW) - 64'd1);

    phase_e          phase_reg, phase_next;
    logic [23:0]     wbuf_reg, wbuf_next;
    logic [1:0]      biw_reg, biw_next;
    logic [3:0]      hidx_reg, hidx_next;
    logic            long_hdr_reg, long_hdr_next;
    logic [DW-1:0]   pwidth_reg, pwidth_next;
    logic [DW-1:0]   pheight_reg, pheight_next;
    logic [SW-1:0]   stride_reg, stride_next;
    logic            fmt_bad_reg, fmt_bad_next;
    logic [31:0]     payload_reg, payload_next;
    logic [31:0]     ppw_reg, ppw_next;
    logic [31:0]     pph_reg, pph_next;
    logic [SW-1:0]   col_reg, col_next;
    logic [DW-1:0]   row_reg, row_next;
    logic [OW-1:0]   woff_reg, woff_next;
    logic [DW-1:0]   live_w_reg, live_w_next;
    logic [DW-1:0]   live_h_reg, live_h_next;
    logic [31:0]     live_pw_reg, live_pw_next;
    logic [31:0]     live_ph_reg, live_ph_next;
    logic [31:0]     dcount_reg, dcount_next;
    logic [SW+DW-1:0] prod_reg;

    logic [31:0]     word;
    logic [SW-1:0]   tight;
    logic [SW-1:0]   col_inc;
    logic [DW-1:0]   row_inc;
    logic            row_done;
    logic [3:0]      hdr_last;
    logic [31:0]     ph_eff;
    logic [31:0]     payload_eff;
    logic            hdr_bad;
    logic [1:0]      n;
    result_t         r0, r1, fr, drop_r;

    assign word    = {data_byte, wbuf_reg};
    assign tight   = SW'({pwidth_reg, 2'b00});
    assign col_inc = col_reg + SW'(1);
    assign row_inc = row_reg + DW'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        wbuf_next     = wbuf_reg;
        biw_next      = biw_reg;
        hidx_next     = hidx_reg;
        long_hdr_next = long_hdr_reg;
        pwidth_next   = pwidth_reg;
        pheight_next  = pheight_reg;
        stride_next   = stride_reg;
        fmt_bad_next  = fmt_bad_reg;
        payload_next  = payload_reg;
        ppw_next      = ppw_reg;
        pph_next      = pph_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        woff_next     = woff_reg;
        live_w_next   = live_w_reg;
        live_h_next   = live_h_reg;
        live_pw_next  = live_pw_reg;
        live_ph_next  = live_ph_reg;
        dcount_next   = dcount_reg;
        row_done      = 1'b0;
        n             = 2'd0;
        r0            = '0;
        r1            = '0;
        fr            = '0;
        drop_r        = '0;
        drop_r.kind   = K_DROP;
        hdr_last      = long_hdr_reg ? HDR_LONG_LAST : HDR_SHORT_LAST;
        ph_eff        = (hidx_reg == HW_PANEL_H) ? word : pph_reg;
        payload_eff   = (hidx_reg == HW_PAYLOAD) ? word : payload_reg;
        hdr_bad = (pwidth_reg == '0) || (pheight_reg == '0)
               || (32'(pwidth_reg) > DIM_MAX) || (32'(pheight_reg) > DIM_MAX)
               || fmt_bad_reg || (stride_reg < tight)
               || (64'(payload_eff) != 64'(prod_reg))
               || (64'(payload_eff) > MAX_BYTES);

        if (take)
        begin
            case (op)
                OP_CONNECT:
                begin
                    phase_next = PH_HELLO;
                    biw_next   = 2'd0;
                    hidx_next  = 4'd0;
                end
                OP_STOP:
                begin
                    phase_next = PH_IDLE;
                end
                OP_BYTE:
                begin
                    case (phase_reg)
                        PH_IDLE:
                        begin
                        end
                        PH_DATA:
                        begin
                            r0.kind         = K_PIXEL;
                            r0.pixel_byte   = data_byte;
                            r0.pixel_offset = 26'(woff_reg);
                            n               = 2'd1;
                            woff_next       = woff_reg + OW'(1);
                            col_next        = col_inc;
                            if (col_inc >= tight)
                            begin
                                if (stride_reg == tight)
                                    row_done = 1'b1;
                                else
                                    phase_next = PH_PAD;
                            end
                        end
                        PH_PAD:
                        begin
                            col_next = col_inc;
                            if (col_inc >= stride_reg)
                                row_done = 1'b1;
                        end
                        default:
                        begin
                            if (biw_reg != 2'd3)
                            begin
                                wbuf_next[biw_reg*8 +: 8] = data_byte;
                                biw_next = biw_reg + 2'd1;
                            end
                            else
                            begin
                                biw_next  = 2'd0;
                                hidx_next = hidx_reg + 4'd1;
                                if (phase_reg inside {PH_HELLO, PH_HELLO_BAD})
                                begin
                                    if (hidx_reg == 4'd0)
                                    begin
                                        phase_next = (word == cfg.hello_magic)
                                                   ? PH_HELLO : PH_HELLO_BAD;
                                    end
                                    else if (phase_reg == PH_HELLO_BAD)
                                    begin
                                        phase_next = PH_IDLE;
                                        r0 = drop_r;
                                        r0.error_code = ERR_HELLO_MAG;
                                        n = 2'd1;
                                    end
                                    else if (word < cfg.min_version
                                             || word > cfg.max_version)
                                    begin
                                        phase_next = PH_IDLE;
                                        r0 = drop_r;
                                        r0.error_code = ERR_VERSION;
                                        n = 2'd1;
                                    end
                                    else
                                    begin
                                        long_hdr_next = (word >= LONG_HDR_VERSION);
                                        live_pw_next  = '0;
                                        live_ph_next  = '0;
                                        phase_next    = PH_HEADER;
                                        hidx_next     = 4'd0;
                                        r0.kind       = K_HELLO;
                                        n             = 2'd1;
                                    end
                                end
                                else
                                begin
                                    case (hidx_reg)
                                        HW_MAGIC:
                                            phase_next = (word == cfg.frame_magic)
                                                       ? PH_HEADER : PH_HEADER_BAD;
                                        HW_WIDTH:
                                            pwidth_next = (word > DIM_MAX)
                                                        ? DIM_SAT : DW'(word);
                                        HW_HEIGHT:
                                            pheight_next = (word > DIM_MAX)
                                                         ? DIM_SAT : DW'(word);
                                        HW_STRIDE:
                                            stride_next = (word > STRIDE_SAT)
                                                        ? '1 : SW'(word);
                                        HW_FORMAT:  fmt_bad_next = (word != '0);
                                        HW_PAYLOAD: payload_next = word;
                                        HW_PANEL_W: ppw_next = word;
                                        HW_PANEL_H: pph_next = word;
                                        default:
                                        begin
                                        end
                                    endcase
                                    if (hidx_reg == hdr_last)
                                    begin
                                        // Both panel values are kept only when both are known.
                                        if (!long_hdr_reg || ppw_reg == '0 || ph_eff == '0)
                                        begin
                                            ppw_next = '0;
                                            pph_next = '0;
                                        end
                                        if (phase_reg == PH_HEADER_BAD)
                                        begin
                                            phase_next = PH_IDLE;
                                            r0 = drop_r;
                                            r0.error_code = ERR_FRAME_MAG;
                                            n = 2'd1;
                                        end
                                        else if (hdr_bad)
                                        begin
                                            phase_next = PH_IDLE;
                                            r0 = drop_r;
                                            r0.error_code = ERR_HEADER;
                                            n = 2'd1;
                                        end
                                        else
                                        begin
                                            phase_next = PH_DATA;
                                            col_next   = '0;
                                            row_next   = '0;
                                            woff_next  = '0;
                                        end
                                    end
                                end
                            end
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end

        if (row_done)
        begin
            col_next = '0;
            row_next = row_inc;
            if (row_inc < pheight_reg)
            begin
                phase_next = PH_DATA;
            end
            else
            begin
                live_w_next  = pwidth_reg;
                live_h_next  = pheight_reg;
                live_pw_next = ppw_reg;
                live_ph_next = pph_reg;
                dcount_next  = dcount_reg + 32'd1;
                phase_next   = PH_HEADER;
                biw_next     = 2'd0;
                hidx_next    = 4'd0;
                fr.kind         = K_FRAME;
                fr.width        = 13'(pwidth_reg);
                fr.height       = 13'(pheight_reg);
                fr.panel_width  = ppw_reg;
                fr.panel_height = pph_reg;
                fr.frame_number = dcount_reg + 32'd1;
                if (n == 2'd0)
                    r0 = fr;
                else
                    r1 = fr;
                n = n + 2'd1;
            end
        end

        if (n == 2'd1)
            r0.last = 1'b1;
        if (n == 2'd2)
            r1.last = 1'b1;
    end

    assign res_count = n;
    assign res0      = r0;
    assign res1      = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            wbuf_reg     <= '0;
            biw_reg      <= '0;
            hidx_reg     <= '0;
            long_hdr_reg <= 1'b0;
            pwidth_reg   <= '0;
            pheight_reg  <= '0;
            stride_reg   <= '0;
            fmt_bad_reg  <= 1'b0;
            payload_reg  <= '0;
            ppw_reg      <= '0;
            pph_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            woff_reg     <= '0;
            live_w_reg   <= '0;
            live_h_reg   <= '0;
            live_pw_reg  <= '0;
            live_ph_reg  <= '0;
            dcount_reg   <= '0;
            prod_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            wbuf_reg     <= wbuf_next;
            biw_reg      <= biw_next;
            hidx_reg     <= hidx_next;
            long_hdr_reg <= long_hdr_next;
            pwidth_reg   <= pwidth_next;
            pheight_reg  <= pheight_next;
            stride_reg   <= stride_next;
            fmt_bad_reg  <= fmt_bad_next;
            payload_reg  <= payload_next;
            ppw_reg      <= ppw_next;
            pph_reg      <= pph_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            woff_reg     <= woff_next;
            live_w_reg   <= live_w_next;
            live_h_reg   <= live_h_next;
            live_pw_reg  <= live_pw_next;
            live_ph_reg  <= live_ph_next;
            dcount_reg   <= dcount_next;
            // Stride and height arrive words before the payload size is judged,
            // so the registered product is settled by then.
            prod_reg     <= (SW+DW)'(stride_reg) * (SW+DW)'(pheight_reg);
        end
    end

    a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
        (res_count == 2'd2) |-> (res0.kind == K_PIXEL && res1.kind == K_FRAME))
        else $error("two results must be a pixel then a publish");

    a_data_dims: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA || phase_reg == PH_PAD)
        |-> (pwidth_reg != '0 && pheight_reg != '0 && stride_reg >= tight))
        else $error("payload phase entered with an unchecked header");

    a_publish_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_count != 2'd0 && (res0.kind == K_FRAME || res1.kind == K_FRAME))
        |=> (dcount_reg == $past(dcount_reg) + 32'd1))
        else $error("publish did not advance the delivery counter");

endmodule

// File: design/cfd_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer result queue
// Small queue; takes up to two results a cycle, hands out one unless stalled.
// ----------------------------------------------------------------------------
module cfd_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_count,
    input  cfd_pkg::result_t push0,
    input  cfd_pkg::result_t push1,
    output logic             full_for_two,
    output logic             out_valid,
    input  logic             out_stall,
    output cfd_pkg::result_t head
);
    import cfd_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    result_t       mem_reg [FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;
    logic [AW-1:0] wr_ptr_p1;

    assign pop          = out_valid && !out_stall;
    assign out_valid    = (count_reg != '0);
    assign head         = mem_reg[rd_ptr_reg];
    assign full_for_two = (count_reg > CW'(FIFO_DEPTH - 2));
    assign wr_ptr_p1    = wr_ptr_reg + AW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push_count);
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(push_count) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem_reg[wr_ptr_reg] <= push0;
        if (push_count == 2'd2)
            mem_reg[wr_ptr_p1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_room_for_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push_count != 2'd0) |-> (CW'(push_count) + count_reg <= CW'(FIFO_DEPTH)))
        else $error("results pushed without room");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != CW'(FIFO_DEPTH)) |-> (AW'(wr_ptr_reg - rd_ptr_reg) == AW'(count_reg)))
        else $error("queue pointers disagree with fill count");

endmodule

// File: design/capture_frame_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capture frame deframer
// Parses a producer byte stream into hello, header and repacked pixel results.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake            Carries
//   input     in         in_valid/in_stall    op, data_byte
//   result    out        out_valid/out_stall  result_kind .. last
//   config    in         cfg_we (no wait)     cfg_index, cfg_data
//
// One input request is taken every cycle unless stalled; its results (at most
// two) are written to a four-entry result queue at the same edge and can leave
// from the next cycle. The input stalls only while the queue has room for fewer
// than two results. Reset clears the parser to idle and the queue to empty;
// the registers return to their defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module capture_frame_deframer_core #(
    parameter int MAX_DIM = cfd_pkg::MAX_DIM_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  pixel_byte,
    output logic [25:0] pixel_offset,
    output logic [12:0] out_width,
    output logic [12:0] out_height,
    output logic [31:0] out_panel_width,
    output logic [31:0] out_panel_height,
    output logic [31:0] frame_number,
    output logic [2:0]  error_code,
    output logic        last,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import cfd_pkg::*;

    cfg_t    cfg_reg;
    logic    take;
    logic [1:0] res_count;
    result_t res0, res1, head;

    assign take = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hello_magic <= 32'h4252_5844;
            cfg_reg.frame_magic <= 32'd0;
            cfg_reg.min_version <= 32'd1;
            cfg_reg.max_version <= 32'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HELLO_MAGIC: cfg_reg.hello_magic <= cfg_data;
                REG_FRAME_MAGIC: cfg_reg.frame_magic <= cfg_data;
                REG_MIN_VERSION: cfg_reg.min_version <= cfg_data;
                REG_MAX_VERSION: cfg_reg.max_version <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    cfd_parse #(
        .MAX_DIM (MAX_DIM)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .take      (take),
        .op        (op),
        .data_byte (data_byte),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    cfd_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_count   (res_count),
        .push0        (res0),
        .push1        (res1),
        .full_for_two (in_stall),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .head         (head)
    );

    assign result_kind      = head.kind;
    assign pixel_byte       = head.pixel_byte;
    assign pixel_offset     = head.pixel_offset;
    assign out_width        = head.width;
    assign out_height       = head.height;
    assign out_panel_width  = head.panel_width;
    assign out_panel_height = head.panel_height;
    assign frame_number     = head.frame_number;
    assign error_code       = head.error_code;
    assign last             = head.last;

endmodule

// File: sim/capture_frame_deframer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capture frame deframer testbench
// Drives hello, header and payload byte sequences, good and broken, into the
// deframer under random idling on both channels, and checks every result
// against a cycle-free predictor of the parser held in a scoreboard class.
// ----------------------------------------------------------------------------
module capture_frame_deframer_core_tb;
    import cfd_pkg::*;

    localparam int MAXD = 4096;

    class deframer_scoreboard;
        logic [31:0] hello_magic, frame_magic, min_version, max_version;
        phase_e      phase;
        logic [31:0] word_buf, version, p_width, p_height, stride, fmt, payload;
        logic [31:0] p_panel_w, p_panel_h, col, row, wr_off, delivered;
        logic [1:0]  byte_idx;
        logic [3:0]  word_idx;
        result_t     expected_results[$];
        int          mismatches, checked, frames, drops;

        function new();
            hello_magic = 32'h4252_5844;
            frame_magic = 0;
            min_version = 1;
            max_version = 2;
            phase = PH_IDLE;
            {word_buf, version, p_width, p_height, stride, fmt, payload} = '0;
            {p_panel_w, p_panel_h, col, row, wr_off, delivered} = '0;
            byte_idx = 0;
            word_idx = 0;
            mismatches = 0;
            checked = 0;
            frames = 0;
            drops = 0;
        endfunction

        function void set_reg(reg_e idx, logic [31:0] v);
            case (idx)
                REG_HELLO_MAGIC: hello_magic = v;
                REG_FRAME_MAGIC: frame_magic = v;
                REG_MIN_VERSION: min_version = v;
                REG_MAX_VERSION: max_version = v;
            endcase
        endfunction

        function result_t blank(kind_e k, err_e e);
            result_t r;
            r = '0;
            r.kind = k;
            r.error_code = e;
            if (k == K_DROP)
                drops++;
            return r;
        endfunction

        function logic [31:0] sat(logic [31:0] v);
            return (v > MAXD) ? MAXD + 1 : v;
        endfunction

        function err_e header_error();
            logic [63:0] w, h;
            w = p_width;
            h = p_height;
            if (phase == PH_HEADER_BAD)
                return ERR_FRAME_MAG;
            if (w == 0 || h == 0 || w > MAXD || h > MAXD || fmt != 0 ||
                64'(stride) < w * 4 || 64'(payload) != 64'(stride) * h ||
                64'(payload) > 64'(MAXD) * MAXD * 4)
                return ERR_HEADER;
            return ERR_NONE;
        endfunction

        function void restart_words();
            word_buf = 0;
            byte_idx = 0;
            word_idx = 0;
        endfunction

        function void finish_row(ref result_t res[$]);
            result_t r;
            col = 0;
            row++;
            if (row < p_height)
            begin
                phase = PH_DATA;
                return;
            end
            delivered++;
            frames++;
            phase = PH_HEADER;
            restart_words();
            r = blank(K_FRAME, ERR_NONE);
            r.width = p_width[12:0];
            r.height = p_height[12:0];
            r.panel_width = p_panel_w;
            r.panel_height = p_panel_h;
            r.frame_number = delivered;
            res.push_back(r);
        endfunction

        function void take_word(logic [31:0] w, ref result_t res[$]);
            logic [3:0]  idx;
            logic [31:0] words;
            err_e        e;
            idx = word_idx;
            word_idx = word_idx + 1;
            if (phase == PH_HELLO || phase == PH_HELLO_BAD)
            begin
                if (idx == 0)
                    phase = (w == hello_magic) ? PH_HELLO : PH_HELLO_BAD;
                else if (phase == PH_HELLO_BAD)
                begin
                    phase = PH_IDLE;
                    res.push_back(blank(K_DROP, ERR_HELLO_MAG));
                end
                else if (w < min_version || w > max_version)
                begin
                    phase = PH_IDLE;
                    res.push_back(blank(K_DROP, ERR_VERSION));
                end
                else
                begin
                    version = w;
                    phase = PH_HEADER;
                    restart_words();
                    res.push_back(blank(K_HELLO, ERR_NONE));
                end
                return;
            end
            case (idx)
                HW_MAGIC:   phase = (w == frame_magic) ? PH_HEADER : PH_HEADER_BAD;
                HW_WIDTH:   p_width = sat(w);
                HW_HEIGHT:  p_height = sat(w);
                HW_STRIDE:  stride = w;
                HW_FORMAT:  fmt = w;
                HW_PAYLOAD: payload = w;
                HW_PANEL_W: p_panel_w = w;
                HW_PANEL_H: p_panel_h = w;
                default: ;
            endcase
            words = (version >= LONG_HDR_VERSION) ? 9 : 7;
            if (32'(idx) + 1 < words)
                return;
            if (words < 9 || p_panel_w == 0 || p_panel_h == 0)
            begin
                p_panel_w = 0;
                p_panel_h = 0;
            end
            e = header_error();
            if (e != ERR_NONE)
            begin
                phase = PH_IDLE;
                res.push_back(blank(K_DROP, e));
                return;
            end
            phase = PH_DATA;
            col = 0;
            row = 0;
            wr_off = 0;
        endfunction

        // Predicts the results of one accepted input request.
        function void note_request(logic [1:0] o, logic [7:0] b);
            result_t res[$];
            result_t r;
            if (o == OP_CONNECT)
            begin
                phase = PH_HELLO;
                restart_words();
                return;
            end
            if (o == OP_STOP)
            begin
                phase = PH_IDLE;
                return;
            end
            if (o != OP_BYTE || phase == PH_IDLE)
                return;
            if (phase == PH_DATA)
            begin
                r = blank(K_PIXEL, ERR_NONE);
                r.pixel_byte = b;
                r.pixel_offset = wr_off[25:0];
                res.push_back(r);
                wr_off++;
                col++;
                if (col >= p_width * 4)
                begin
                    if (stride == p_width * 4)
                        finish_row(res);
                    else
                        phase = PH_PAD;
                end
            end
            else if (phase == PH_PAD)
            begin
                col++;
                if (col >= stride)
                    finish_row(res);
            end
            else
            begin
                word_buf = word_buf | (32'(b) << (8 * byte_idx));
                byte_idx++;
                if (byte_idx == 0)
                begin
                    take_word(word_buf, res);
                    word_buf = 0;
                end
            end
            if (res.size() > 0)
                res[res.size() - 1].last = 1'b1;
            foreach (res[i])
                expected_results.push_back(res[i]);
        endfunction

        function void check_result(result_t act);
            result_t exp;
            checked++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing expected: %p", act);
                return;
            end
            exp = expected_results.pop_front();
            if (act.kind !== exp.kind || act.pixel_byte !== exp.pixel_byte ||
                act.pixel_offset !== exp.pixel_offset || act.width !== exp.width ||
                act.height !== exp.height || act.panel_width !== exp.panel_width ||
                act.panel_height !== exp.panel_height ||
                act.frame_number !== exp.frame_number ||
                act.error_code !== exp.error_code || act.last !== exp.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: mismatch\n  expected %p\n  actual   %p", exp, act);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  result_kind;
    logic [7:0]  pixel_byte;
    logic [25:0] pixel_offset;
    logic [12:0] out_width;
    logic [12:0] out_height;
    logic [31:0] out_panel_width;
    logic [31:0] out_panel_height;
    logic [31:0] frame_number;
    logic [2:0]  error_code;
    logic        last;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    deframer_scoreboard sb;
    int  requests_sent;
    int  idle_cycles;
    int  stall_left;
    bit  gaps_on;
    bit  stalls_on;
    bit  timed_out;

    capture_frame_deframer_core DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .op               (op),
        .data_byte        (data_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_kind      (result_kind),
        .pixel_byte       (pixel_byte),
        .pixel_offset     (pixel_offset),
        .out_width        (out_width),
        .out_height       (out_height),
        .out_panel_width  (out_panel_width),
        .out_panel_height (out_panel_height),
        .frame_number     (frame_number),
        .error_code       (error_code),
        .last             (last),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Result monitor: values are stable at the falling edge, and a result
    // seen valid and unstalled there is taken at the next rising edge.
    always @(negedge clk)
    begin
        result_t act;
        if (rst_n && out_valid && !out_stall)
        begin
            act.kind = kind_e'(result_kind);
            act.pixel_byte = pixel_byte;
            act.pixel_offset = pixel_offset;
            act.width = out_width;
            act.height = out_height;
            act.panel_width = out_panel_width;
            act.panel_height = out_panel_height;
            act.frame_number = frame_number;
            act.error_code = err_e'(error_code);
            act.last = last;
            sb.check_result(act);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (stalls_on && $urandom_range(0, 3) == 0)
        begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= 5000)
        begin
            timed_out = 1'b1;
            $display("capture_frame_deframer_core test failed");
            $finish;
        end
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(logic [1:0] o, logic [7:0] b);
        int g;
        in_valid <= 1'b1;
        op <= o;
        data_byte <= b;
        do
            @(negedge clk);
        while (in_stall);
        sb.note_request(o, b);
        @(posedge clk);
        requests_sent++;
        g = gap_length();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            send_request(OP_BYTE, w[8 * i +: 8]);
    endtask

    task automatic send_hello(logic [31:0] magic, logic [31:0] ver);
        send_request(OP_CONNECT, 8'($urandom));
        send_word(magic);
        send_word(ver);
    endtask

    // Header in the length the accepted version calls for, then pixel bytes.
    task automatic send_frame(logic [31:0] magic, logic [31:0] w, logic [31:0] h,
                              logic [31:0] strd, logic [31:0] pf, logic [31:0] pay,
                              logic [31:0] pw, logic [31:0] ph, int nbytes);
        send_word(magic);
        send_word($urandom);
        send_word(w);
        send_word(h);
        send_word(strd);
        send_word(pf);
        send_word(pay);
        if (sb.version >= LONG_HDR_VERSION)
        begin
            send_word(pw);
            send_word(ph);
        end
        for (int i = 0; i < nbytes; i++)
            send_request(OP_BYTE, 8'($urandom));
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (sb.expected_results.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(reg_e idx, logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        sb.set_reg(idx, v);
    endtask

    task automatic set_config(logic [31:0] hm, logic [31:0] fm, logic [31:0] lo,
                              logic [31:0] hi);
        in_valid <= 1'b0;
        wait_drained();
        write_reg(REG_HELLO_MAGIC, hm);
        write_reg(REG_FRAME_MAGIC, fm);
        write_reg(REG_MIN_VERSION, lo);
        write_reg(REG_MAX_VERSION, hi);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_version();
        logic [63:0] span;
        if (sb.min_version > sb.max_version)
            return $urandom;
        span = 64'(sb.max_version) - sb.min_version + 1;
        case ($urandom_range(0, 2))
            0: return sb.min_version;
            1: return sb.max_version;
            default: return 32'(sb.min_version + ({$urandom, $urandom} % span));
        endcase
    endfunction

    // One connection: hello, a few frames, some of them broken, then sometimes a stop or noise.
    task automatic random_session();
        logic [31:0] w, h, strd, pay, pf, magic, pw, ph;
        int r, nb;
        r = $urandom_range(0, 99);
        if (r < 80)
            send_hello(sb.hello_magic, pick_version());
        else if (r < 90)
            send_hello(sb.hello_magic ^ (32'd1 << $urandom_range(0, 31)), pick_version());
        else
            send_hello(sb.hello_magic, $urandom);
        for (int f = 0; f < $urandom_range(1, 4) && sb.phase == PH_HEADER; f++)
        begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
            h = $urandom_range(1, 3);
            strd = w * 4 + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5));
            pay = strd * h;
            pf = 0;
            magic = sb.frame_magic;
            pw = ($urandom_range(0, 3) == 0) ? 0 : $urandom;
            ph = ($urandom_range(0, 3) == 0) ? 0 : $urandom;
            if ($urandom_range(0, 99) < 15)
            begin
                case ($urandom_range(0, 6))
                    0: magic = magic ^ (32'd1 << $urandom_range(0, 31));
                    1: w = 0;
                    2: h = $urandom_range(MAXD + 1, 65535);
                    3: pf = 32'd1 << $urandom_range(0, 31);
                    4: strd = w * 4 - 1;
                    5: pay = pay + 1;
                    default: pay = pay - 1;
                endcase
            end
            nb = pay;
            if (nb > 200)
                nb = 8;
            if ($urandom_range(0, 9) == 0)
                nb = $urandom_range(0, nb);
            send_frame(magic, w, h, strd, pf, pay, pw, ph, nb);
        end
        r = $urandom_range(0, 9);
        if (r < 3)
            send_request(OP_STOP, 8'($urandom));
        else if (r < 5)
            for (int i = 0; i < $urandom_range(1, 6); i++)
                send_request(2'($urandom_range(0, 3)), 8'($urandom));
    endtask

    task automatic random_phase(int n_requests);
        int stop_at;
        stop_at = requests_sent + n_requests;
        while (requests_sent < stop_at)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            random_session();
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_BYTE;
        data_byte = 8'h00;
        cfg_we = 1'b0;
        cfg_index = REG_HELLO_MAGIC;
        cfg_data = '0;
        out_stall = 1'b0;
        stall_left = 0;
        requests_sent = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle bytes, unused op code, good frames in both header
        // lengths, a padded one, and each kind of drop.
        send_request(OP_BYTE, 8'hFF);
        send_request(2'd3, 8'h00);
        send_hello(32'h4252_5844, 32'd1);
        send_frame(32'd0, 1, 1, 4, 0, 4, 0, 0, 4);
        send_request(OP_CONNECT, 8'h00);
        send_hello(32'h4252_5844, 32'd2);
        send_frame(32'd0, 2, 2, 11, 0, 22, 1920, 1080, 22);
        send_frame(32'd0, 1, 1, 4, 0, 4, 0, 7, 4);
        send_frame(32'd0, MAXD, 1, MAXD * 4, 0, MAXD * 4, 0, 0, 3);
        send_request(OP_STOP, 8'h00);
        send_hello(32'h4252_5844, 32'd2);
        send_frame(32'd0, MAXD + 1, 1, 0, 0, 0, 1, 1, 0);
        send_hello(32'h4252_5844, 32'd1);
        send_frame(32'd0, 1, 2, 32'h8000_0000, 0, 0, 0, 0, 0);
        send_hello(32'h4252_5844, 32'd1);
        send_frame(32'hFFFF_FFFF, 1, 1, 4, 0, 4, 0, 0, 0);
        send_hello(32'hBDAD_A7BB, 32'd1);
        send_hello(32'h4252_5844, 32'd3);
        send_hello(32'h4252_5844, 32'd0);
        send_hello(32'h4252_5844, 32'd1);
        send_frame(32'd0, 1, 1, 4, 0, 4, 0, 0, 2);
        send_request(OP_CONNECT, 8'h00);

        random_phase(90);
        set_config(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        random_phase(80);
        set_config(32'hFFFF_FFFF, 32'h1234_5678, 32'd5, 32'd5);
        random_phase(60);
        set_config($urandom, $urandom, 32'd3, 32'd1);
        random_phase(30);
        set_config(32'h4252_5844, 32'd0, 32'd1, 32'd2);
        random_phase(70);

        in_valid <= 1'b0;
        wait_drained();
        $display("Sent %0d input requests over five register settings.", requests_sent);
        $display("Checked %0d results: %0d frames published, %0d drops, %0d mismatches.",
                 sb.checked, sb.frames, sb.drops, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0 && !timed_out)
            $display("capture_frame_deframer_core test passed");
        else
            $display("capture_frame_deframer_core test failed");
        $finish;
    end

endmodule

// File: capture_frame_deframer_core.f
design/cfd_pkg.sv
design/cfd_parse.sv
design/cfd_outq.sv
design/capture_frame_deframer_core.sv
sim/capture_frame_deframer_core_tb.sv
